@@ rtl/spq_pkg.sv @@
// shared types and constants for the stable priority queue
`default_nettype none

package spq_pkg;

    localparam int CAPACITY      = 16;
    localparam int VALUE_BITS    = 32;
    localparam int PRIORITY_BITS = 16;
    localparam int COUNT_BITS    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } t_err;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

`default_nettype wire

@@ rtl/spq_in_if.sv @@
// request channel: valid/ready with one operation word
`default_nettype none

interface spq_in_if
    import spq_pkg::*;
();
    logic                            valid;
    logic                            ready;
    logic [1:0]                      mode;
    logic signed [VALUE_BITS-1:0]    item_value;
    logic signed [PRIORITY_BITS-1:0] item_priority;

    modport source (output valid, output mode, output item_value, output item_priority,
                    input ready);
    modport sink   (input valid, input mode, input item_value, input item_priority,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/spq_out_if.sv @@
// result channel: valid/ready with one status word
`default_nettype none

interface spq_out_if
    import spq_pkg::*;
();
    logic                            valid;
    logic                            ready;
    logic                            removed_valid;
    logic signed [VALUE_BITS-1:0]    removed_value;
    logic signed [PRIORITY_BITS-1:0] removed_priority;
    logic signed [VALUE_BITS-1:0]    head_value;
    logic signed [PRIORITY_BITS-1:0] head_priority;
    logic [COUNT_BITS-1:0]           entry_count;
    logic                            is_empty;
    logic [1:0]                      error_code;

    modport source (output valid, output removed_valid, output removed_value,
                    output removed_priority, output head_value, output head_priority,
                    output entry_count, output is_empty, output error_code,
                    input ready);
    modport sink   (input valid, input removed_valid, input removed_value,
                    input removed_priority, input head_value, input head_priority,
                    input entry_count, input is_empty, input error_code,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/stable_priority_queue_unit.sv @@
// top level of the stable priority queue
`default_nettype none

// Sorted priority queue of CAPACITY entries (value plus signed priority), kept
// in ascending priority order in a row of cells that all compare against the
// new priority at once; a push lands after every entry of equal or lower
// priority, so ties leave in arrival order. Each request word (push, pop or
// clear) yields one result word with the removed entry, the new head, the count,
// an empty flag and an error code; push on full and pop on empty change nothing.
// A request is latched in the idle state; in the execute state the cells shift or
// insert and the result register loads. The result register frees the
// request side, so a new word is taken while the last result waits; the execute
// step then holds until that result has been taken.
module stable_priority_queue_unit
    import spq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);

    t_dp_cmd cmd;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    spq_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_mode             (i_in.mode),
        .i_item_value       (i_in.item_value),
        .i_item_priority    (i_in.item_priority),
        .o_removed_valid    (o_out.removed_valid),
        .o_removed_value    (o_out.removed_value),
        .o_removed_priority (o_out.removed_priority),
        .o_head_value       (o_out.head_value),
        .o_head_priority    (o_out.head_priority),
        .o_entry_count      (o_out.entry_count),
        .o_is_empty         (o_out.is_empty),
        .o_error_code       (o_out.error_code)
    );

endmodule

`default_nettype wire

@@ rtl/spq_ctrl.sv @@
// controller: sequences accept, execute and result handoff
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire logic i_out_ready,
    output logic      o_out_valid,
    output t_dp_cmd   o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   exec_ok;

    // the result register must be free before the next op overwrites it
    assign exec_ok = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_ok) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec = exec_ok;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ rtl/spq_datapath.sv @@
// datapath: row of sorted cells with parallel compare, plus result register
`default_nettype none

module spq_datapath
    import spq_pkg::*;
(
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire t_dp_cmd                         i_cmd,
    input  wire logic [1:0]                      i_mode,
    input  wire logic signed [VALUE_BITS-1:0]    i_item_value,
    input  wire logic signed [PRIORITY_BITS-1:0] i_item_priority,
    output logic                                 o_removed_valid,
    output logic signed [VALUE_BITS-1:0]         o_removed_value,
    output logic signed [PRIORITY_BITS-1:0]      o_removed_priority,
    output logic signed [VALUE_BITS-1:0]         o_head_value,
    output logic signed [PRIORITY_BITS-1:0]      o_head_priority,
    output logic [COUNT_BITS-1:0]                o_entry_count,
    output logic                                 o_is_empty,
    output logic [1:0]                           o_error_code
);

    // latched request
    logic [1:0]                      r_mode;
    logic signed [VALUE_BITS-1:0]    r_new_val;
    logic signed [PRIORITY_BITS-1:0] r_new_pri;

    // cells, head at index 0
    logic signed [VALUE_BITS-1:0]    r_val [CAPACITY];
    logic signed [PRIORITY_BITS-1:0] r_pri [CAPACITY];
    logic signed [VALUE_BITS-1:0]    n_val [CAPACITY];
    logic signed [PRIORITY_BITS-1:0] n_pri [CAPACITY];
    logic [COUNT_BITS-1:0]           r_count, n_count;

    logic [CAPACITY-1:0]             stay;
    logic                            full, empty;
    t_err                            err;
    logic                            rem_valid;

    // result register
    logic                            r_removed_valid;
    logic signed [VALUE_BITS-1:0]    r_removed_value;
    logic signed [PRIORITY_BITS-1:0] r_removed_priority;
    logic signed [VALUE_BITS-1:0]    r_head_value;
    logic signed [PRIORITY_BITS-1:0] r_head_priority;
    logic [COUNT_BITS-1:0]           r_entry_count;
    logic                            r_is_empty;
    logic [1:0]                      r_error_code;

    assign full  = (r_count >= COUNT_BITS'(CAPACITY));
    assign empty = (r_count == '0);

    // a cell keeps its entry when it is occupied and not above the new priority;
    // the sorted order makes this a prefix
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            stay[i] = (COUNT_BITS'(i) < r_count) && (r_pri[i] <= r_new_pri);
        end
    end

    always_comb begin
        n_count   = r_count;
        err       = ERR_OK;
        rem_valid = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            n_val[i] = r_val[i];
            n_pri[i] = r_pri[i];
        end
        case (r_mode)
            MODE_PUSH: begin
                if (full) begin
                    err = ERR_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (stay[i]) begin
                            n_val[i] = r_val[i];
                            n_pri[i] = r_pri[i];
                        end else if (i == 0) begin
                            n_val[i] = r_new_val;
                            n_pri[i] = r_new_pri;
                        end else if (stay[(i == 0) ? 0 : i - 1]) begin
                            n_val[i] = r_new_val;
                            n_pri[i] = r_new_pri;
                        end else begin
                            n_val[i] = r_val[(i == 0) ? 0 : i - 1];
                            n_pri[i] = r_pri[(i == 0) ? 0 : i - 1];
                        end
                    end
                end
            end
            MODE_POP: begin
                if (empty) begin
                    err = ERR_EMPTY;
                end else begin
                    rem_valid = 1'b1;
                    n_count   = r_count - 1'b1;
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        n_val[i] = r_val[i + 1];
                        n_pri[i] = r_pri[i + 1];
                    end
                end
            end
            MODE_CLEAR: begin
                n_count = '0;
            end
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_new_val <= i_item_value;
            r_new_pri <= i_item_priority;
        end
        if (i_cmd.exec) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_val[i] <= n_val[i];
                r_pri[i] <= n_pri[i];
            end
            r_removed_valid    <= rem_valid;
            r_removed_value    <= rem_valid ? r_val[0] : '0;
            r_removed_priority <= rem_valid ? r_pri[0] : '0;
            r_head_value       <= (n_count != '0) ? n_val[0] : '0;
            r_head_priority    <= (n_count != '0) ? n_pri[0] : '0;
            r_entry_count      <= n_count;
            r_is_empty         <= (n_count == '0);
            r_error_code       <= err;
        end
    end

    assign o_removed_valid    = r_removed_valid;
    assign o_removed_value    = r_removed_value;
    assign o_removed_priority = r_removed_priority;
    assign o_head_value       = r_head_value;
    assign o_head_priority    = r_head_priority;
    assign o_entry_count      = r_entry_count;
    assign o_is_empty         = r_is_empty;
    assign o_error_code       = r_error_code;

endmodule

`default_nettype wire
